// ===== rtl/tlc_pkg.sv =====
// shared types and constants for the traffic light controller
// no dependencies
`default_nettype none

package tlc_pkg;

  localparam int CntW = 16;
  localparam int SecW = 7;
  localparam int LvlW = 12;
  localparam int NumW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_GREEN       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_YELLOW      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RED         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TICKS_SEC   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BLINK_TICKS = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SHORT_GREEN = 3'd6;

  // register reset values
  localparam logic [SecW-1:0] GREEN_RST       = 7'd5;
  localparam logic [SecW-1:0] YELLOW_RST      = 7'd2;
  localparam logic [SecW-1:0] RED_RST         = 7'd5;
  localparam logic [LvlW-1:0] THRESHOLD_RST   = 12'd1000;
  localparam logic [CntW-1:0] TICKS_SEC_RST   = 16'd1000;
  localparam logic [CntW-1:0] BLINK_TICKS_RST = 16'd500;
  localparam logic [SecW-1:0] SHORT_GREEN_RST = 7'd2;

  // phase codes
  localparam logic [1:0] PH_GREEN  = 2'd0;
  localparam logic [1:0] PH_YELLOW = 2'd1;
  localparam logic [1:0] PH_RED    = 2'd2;

  // lamp bit patterns: red, yellow, green
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_GREEN  = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_RED    = 3'b100;

  typedef struct packed {
    logic [SecW-1:0] green_seconds;
    logic [SecW-1:0] yellow_seconds;
    logic [SecW-1:0] red_seconds;
    logic [LvlW-1:0] dark_level;
    logic [CntW-1:0] ticks_per_second;
    logic [CntW-1:0] blink_ticks;
    logic [SecW-1:0] short_green_seconds;
  } cfg_t;

  typedef struct packed {
    logic [2:0]             lamps;
    logic                   street;
    logic                   dashes;
    logic signed [NumW-1:0] number;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tlc_tick_cnt.sv =====
// saturating tick counter with period event, clears on event when allowed
// depends on tlc_pkg
`default_nettype none

module tlc_tick_cnt
  import tlc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [CntW-1:0] period,
  input  wire logic            clr_ok,
  output logic                 fire
);

  logic [CntW-1:0] cnt_r, cnt_nxt, inc;

  assign inc  = (cnt_r == {CntW{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign fire = (inc >= period);

  always_comb begin
    cnt_nxt = cnt_r;
    if (en) begin
      cnt_nxt = (fire && clr_ok) ? '0 : inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlc_light_fsm.sv =====
// phase sequencer, countdown, blink and display state
// depends on tlc_pkg
`default_nettype none

module tlc_light_fsm
  import tlc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    night,
  input  wire logic    button,
  input  wire logic    sec_fire,
  input  wire logic    blink_fire,
  input  wire cfg_t    cfg,
  output result_t      res
);

  logic [1:0]             phase_r, phase_nxt;
  logic signed [NumW-1:0] left_r, left_nxt;
  logic                   blink_r, blink_nxt;
  logic [2:0]             lamp_r, lamp_nxt;
  logic signed [NumW-1:0] shown_r, shown_nxt;
  logic                   dash_r, dash_nxt;
  logic signed [NumW-1:0] dec;
  logic signed [NumW-1:0] short_s;

  assign dec     = left_r - 8'sd1;
  assign short_s = $signed({1'b0, cfg.short_green_seconds});

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    blink_nxt = blink_r;
    lamp_nxt  = lamp_r;
    shown_nxt = shown_r;
    dash_nxt  = dash_r;
    if (night) begin
      dash_nxt = 1'b1;
      if (blink_fire) begin
        blink_nxt = !blink_r;
        lamp_nxt  = blink_nxt ? LAMP_YELLOW : LAMP_OFF;
      end
      phase_nxt = PH_GREEN;
      left_nxt  = $signed({1'b0, cfg.green_seconds});
    end else begin
      if (sec_fire) begin
        shown_nxt = dec;
        dash_nxt  = 1'b0;
        left_nxt  = dec;
        if (dec < 0) begin
          case (phase_r)
            PH_GREEN: begin
              phase_nxt = PH_YELLOW;
              left_nxt  = $signed({1'b0, cfg.yellow_seconds});
            end
            PH_YELLOW: begin
              phase_nxt = PH_RED;
              left_nxt  = $signed({1'b0, cfg.red_seconds});
            end
            default: begin
              phase_nxt = PH_GREEN;
              left_nxt  = $signed({1'b0, cfg.green_seconds});
            end
          endcase
        end
      end
      case (phase_nxt)
        PH_GREEN:  lamp_nxt = LAMP_GREEN;
        PH_YELLOW: lamp_nxt = LAMP_YELLOW;
        default:   lamp_nxt = LAMP_RED;
      endcase
      // pedestrian request shortens green
      if (button && (phase_nxt == PH_GREEN) && (left_nxt > short_s)) begin
        left_nxt  = short_s;
        shown_nxt = short_s;
        dash_nxt  = 1'b0;
      end
    end
  end

  assign res.lamps  = lamp_nxt;
  assign res.street = night;
  assign res.dashes = dash_nxt;
  assign res.number = shown_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GREEN;
      left_r  <= $signed({1'b0, GREEN_RST});
      blink_r <= 1'b0;
      lamp_r  <= LAMP_OFF;
      shown_r <= '0;
      dash_r  <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      blink_r <= blink_nxt;
      lamp_r  <= lamp_nxt;
      shown_r <= shown_nxt;
      dash_r  <= dash_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/traffic_light_day_night_controller.sv =====
// an accepted item passes the input reg, then the result reg, before result valid
// throughput: one item per cycle while out_stall is low; the state updates as each item advances
// the input register still takes an item while a result waits, stall only when both are full
// reset (rst_n low, synchronous) loads register defaults, phase green,
// countdown 5, counters, blink, lamps, display cleared, both stages empty
// depends on tlc_pkg, tlc_tick_cnt, tlc_light_fsm
`default_nettype none

module traffic_light_day_night_controller
  import tlc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LvlW-1:0]      in_light_level,
  input  wire logic                 in_button_pressed,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_red_lamp,
  output logic                      out_yellow_lamp,
  output logic                      out_green_lamp,
  output logic                      out_street_lamp,
  output logic                      out_show_dashes,
  output logic signed [NumW-1:0]    out_display_number,
  // configuration write port
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfg_t cfg_r;

  // input stage
  logic            in_v_r;
  logic [LvlW-1:0] level_r;
  logic            button_r;

  // result stage
  logic    out_v_r;
  result_t res_r;
  result_t res;

  logic advance;   // input stage item moves to the result stage
  logic in_acc;
  logic night;
  logic sec_fire, blink_fire;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign night = (level_r < cfg_r.dark_level);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_seconds       <= GREEN_RST;
      cfg_r.yellow_seconds      <= YELLOW_RST;
      cfg_r.red_seconds         <= RED_RST;
      cfg_r.dark_level          <= THRESHOLD_RST;
      cfg_r.ticks_per_second    <= TICKS_SEC_RST;
      cfg_r.blink_ticks         <= BLINK_TICKS_RST;
      cfg_r.short_green_seconds <= SHORT_GREEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GREEN:       cfg_r.green_seconds       <= cfg_data[SecW-1:0];
        REG_YELLOW:      cfg_r.yellow_seconds      <= cfg_data[SecW-1:0];
        REG_RED:         cfg_r.red_seconds         <= cfg_data[SecW-1:0];
        REG_THRESHOLD:   cfg_r.dark_level          <= cfg_data[LvlW-1:0];
        REG_TICKS_SEC:   cfg_r.ticks_per_second    <= cfg_data[CntW-1:0];
        REG_BLINK_TICKS: cfg_r.blink_ticks         <= cfg_data[CntW-1:0];
        REG_SHORT_GREEN: cfg_r.short_green_seconds <= cfg_data[SecW-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      level_r  <= in_light_level;
      button_r <= in_button_pressed;
    end
  end

  // second counter clears only in day mode, blink counter only at night
  tlc_tick_cnt u_sec_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .period (cfg_r.ticks_per_second),
    .clr_ok (!night),
    .fire   (sec_fire)
  );

  tlc_tick_cnt u_blink_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .period (cfg_r.blink_ticks),
    .clr_ok (night),
    .fire   (blink_fire)
  );

  tlc_light_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .night      (night),
    .button     (button_r),
    .sec_fire   (sec_fire),
    .blink_fire (blink_fire),
    .cfg        (cfg_r),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_red_lamp       = res_r.lamps[2];
  assign out_yellow_lamp    = res_r.lamps[1];
  assign out_green_lamp     = res_r.lamps[0];
  assign out_street_lamp    = res_r.street;
  assign out_show_dashes    = res_r.dashes;
  assign out_display_number = res_r.number;

endmodule

`default_nettype wire

// ===== tb/tb_traffic_light_day_night_controller.sv =====
// self-checking testbench for traffic_light_day_night_controller
// drives light/button ticks and register writes, predicts every lamp/display item
// depends on tlc_pkg and the controller rtl only
`timescale 1ns / 100ps

module tb_traffic_light_day_night_controller
  import tlc_pkg::*;
();

  // two register stages between input accept and result valid
  localparam int PIPE_LAT = 2;
  // generous ceiling on the length of the whole run
  localparam int CYCLE_LIMIT = 200_000;
  // index past the last register, must be ignored by the block
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [LvlW-1:0]      level;
    logic                 button;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic                 typed;   // expected item written out by hand
    result_t              want;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [LvlW-1:0] in_light_level = '0;
  logic in_button_pressed = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic out_red_lamp;
  logic out_yellow_lamp;
  logic out_green_lamp;
  logic out_street_lamp;
  logic out_show_dashes;
  logic signed [NumW-1:0] out_display_number;
  logic cfg_ready;

  always #6 clk = ~clk;

  traffic_light_day_night_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_light_level     (in_light_level),
    .in_button_pressed  (in_button_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_red_lamp       (out_red_lamp),
    .out_yellow_lamp    (out_yellow_lamp),
    .out_green_lamp     (out_green_lamp),
    .out_street_lamp    (out_street_lamp),
    .out_show_dashes    (out_show_dashes),
    .out_display_number (out_display_number),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // controller predictor: register copy plus light sequence state
  // ---------------------------------------------------------------------------
  cfg_t                   live_cfg;
  logic [1:0]             light_phase;
  int                     secs_left;       // signed countdown, dips to -1 briefly
  logic [CntW-1:0]        sec_ticks;       // ticks since last countdown step
  logic [CntW-1:0]        blink_ticks_seen;
  logic                   blink_lit;
  logic [2:0]             lamp_drive;      // red, yellow, green
  logic signed [NumW-1:0] shown_num;
  logic                   dash_on;

  // lamp/display items still owed by the block, oldest first
  result_t due_outputs[$];

  // one millisecond tick of the controller
  task automatic advance_one_tick(input logic [LvlW-1:0] level, input logic button,
                                  output result_t r);
    logic night;
    night = level < live_cfg.dark_level;
    // both counters run in either mode and stick at the 16-bit ceiling
    if (sec_ticks != '1) sec_ticks++;
    if (blink_ticks_seen != '1) blink_ticks_seen++;
    if (night) begin
      dash_on = 1'b1;
      // between blinks the lamps hold whatever they drove before
      if (blink_ticks_seen >= live_cfg.blink_ticks) begin
        blink_ticks_seen = '0;
        blink_lit = ~blink_lit;
        lamp_drive = blink_lit ? LAMP_YELLOW : LAMP_OFF;
      end
      light_phase = PH_GREEN;
      secs_left = live_cfg.green_seconds;
    end else begin
      if (sec_ticks >= live_cfg.ticks_per_second) begin
        sec_ticks = '0;
        secs_left--;
        shown_num = secs_left[NumW-1:0];
        dash_on = 1'b0;
        if (secs_left < 0) begin
          case (light_phase)
            PH_GREEN: begin
              light_phase = PH_YELLOW;
              secs_left = live_cfg.yellow_seconds;
            end
            PH_YELLOW: begin
              light_phase = PH_RED;
              secs_left = live_cfg.red_seconds;
            end
            default: begin
              light_phase = PH_GREEN;
              secs_left = live_cfg.green_seconds;
            end
          endcase
        end
      end
      case (light_phase)
        PH_GREEN:  lamp_drive = LAMP_GREEN;
        PH_YELLOW: lamp_drive = LAMP_YELLOW;
        default:   lamp_drive = LAMP_RED;   // unused code 3 acts as red
      endcase
      // pedestrian request shortens green, no debounce delay
      if (button && light_phase == PH_GREEN && secs_left > int'(live_cfg.short_green_seconds))
      begin
        secs_left = live_cfg.short_green_seconds;
        shown_num = secs_left[NumW-1:0];
        dash_on = 1'b0;
      end
    end
    r.lamps = lamp_drive;
    r.street = night;
    r.dashes = dash_on;
    r.number = shown_num;
  endtask

  // ---------------------------------------------------------------------------
  // idling knobs shared by the sender and the receiver
  // ---------------------------------------------------------------------------
  bit idle_on = 1'b1;
  int gap_pct = 20;
  int stall_pct = 20;
  bit long_hold_req = 1'b0;   // sender asks the receiver for a long hold-off
  int hold_left = 0;
  int burst_left = 0;

  // receiver: random stall bursts, one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = 400;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_on && burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_on && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      burst_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  int errors = 0;
  result_t got_item;
  result_t want_item;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_item.lamps = {out_red_lamp, out_yellow_lamp, out_green_lamp};
      got_item.street = out_street_lamp;
      got_item.dashes = out_show_dashes;
      got_item.number = out_display_number;
      if (due_outputs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: lamps %b street %b dashes %b number %0d",
                   got_item.lamps, got_item.street, got_item.dashes, got_item.number);
      end else begin
        want_item = due_outputs.pop_front();
        if (got_item.lamps !== want_item.lamps || got_item.street !== want_item.street ||
            got_item.dashes !== want_item.dashes || got_item.number !== want_item.number)
        begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected lamps %b street %b dashes %b number %0d, %s",
                     want_item.lamps, want_item.street, want_item.dashes, want_item.number,
                     $sformatf("got lamps %b street %b dashes %b number %0d",
                               got_item.lamps, got_item.street, got_item.dashes,
                               got_item.number));
        end
      end
    end
  end

  // run watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_traffic_light_day_night_controller: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // random idle burst on the input channel
  task automatic sender_gap();
    int n;
    if (idle_on && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // present one tick, hold it until accepted, then log what it must produce
  task automatic offer_tick(input logic [LvlW-1:0] level, input logic button,
                            input logic typed, input result_t want);
    result_t r;
    @(negedge clk);
    in_valid <= 1'b1;
    in_light_level <= level;
    in_button_pressed <= button;
    do @(posedge clk); while (in_stall);
    advance_one_tick(level, button, r);
    due_outputs.push_back(typed ? want : r);
  endtask

  // stop sending and let every owed item come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // one register write; data is masked to the register width
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GREEN:       live_cfg.green_seconds = data[SecW-1:0];
      REG_YELLOW:      live_cfg.yellow_seconds = data[SecW-1:0];
      REG_RED:         live_cfg.red_seconds = data[SecW-1:0];
      REG_THRESHOLD:   live_cfg.dark_level = data[LvlW-1:0];
      REG_TICKS_SEC:   live_cfg.ticks_per_second = data[CntW-1:0];
      REG_BLINK_TICKS: live_cfg.blink_ticks = data[CntW-1:0];
      REG_SHORT_GREEN: live_cfg.short_green_seconds = data[SecW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full register set, junk in the bits above each register's width
  task automatic load_settings(input int g, input int y, input int r, input int thr,
                               input int tps, input int blink, input int sg);
    write_reg(REG_GREEN, {9'($urandom), 7'(g)});
    write_reg(REG_YELLOW, {9'($urandom), 7'(y)});
    write_reg(REG_RED, {9'($urandom), 7'(r)});
    write_reg(REG_THRESHOLD, {4'($urandom), 12'(thr)});
    write_reg(REG_TICKS_SEC, 16'(tps));
    write_reg(REG_BLINK_TICKS, 16'(blink));
    write_reg(REG_SHORT_GREEN, {9'($urandom), 7'(sg)});
  endtask

  // directed plan builders
  plan_row_t plan[$];

  function automatic void tick_row(input logic [LvlW-1:0] level, input logic button);
    plan.push_back('{ROW_TICK, level, button, '0, '0, 1'b0, '0});
  endfunction

  function automatic void typed_row(input logic [LvlW-1:0] level, input logic button,
                                    input result_t want);
    plan.push_back('{ROW_TICK, level, button, '0, '0, 1'b1, want});
  endfunction

  function automatic void write_row(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    plan.push_back('{ROW_WRITE, '0, 1'b0, idx, data, 1'b0, '0});
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    result_t none;
    logic [LvlW-1:0] lvl;
    logic btn;
    int thr;
    int run_left;
    bit run_night;
    bit press_run;

    none = '0;
    // predictor starts from the register defaults and a fresh green phase
    live_cfg.green_seconds = GREEN_RST;
    live_cfg.yellow_seconds = YELLOW_RST;
    live_cfg.red_seconds = RED_RST;
    live_cfg.dark_level = THRESHOLD_RST;
    live_cfg.ticks_per_second = TICKS_SEC_RST;
    live_cfg.blink_ticks = BLINK_TICKS_RST;
    live_cfg.short_green_seconds = SHORT_GREEN_RST;
    light_phase = PH_GREEN;
    secs_left = GREEN_RST;
    sec_ticks = '0;
    blink_ticks_seen = '0;
    blink_lit = 1'b0;
    lamp_drive = LAMP_OFF;
    shown_num = '0;
    dash_on = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // reset defaults: brightest day tick lights green, display still blank at 0
    typed_row(12'd4095, 1'b0, '{LAMP_GREEN, 1'b0, 1'b0, 8'sd0});
    // darkest tick: night, lamps keep their drive until the first blink
    typed_row(12'd0, 1'b1, '{LAMP_GREEN, 1'b1, 1'b1, 8'sd0});
    tick_row(12'd999, 1'b0);                                 // just under threshold
    // at threshold it is day; button cuts green 5 down to 2 and clears dashes
    typed_row(12'd1000, 1'b1, '{LAMP_GREEN, 1'b0, 1'b0, 8'sd2});
    // zero period fires every tick; green 0 via masked write, red 99
    write_row(REG_TICKS_SEC, 16'd0);
    write_row(REG_GREEN, 16'hFF80);
    write_row(REG_YELLOW, 16'd1);
    write_row(REG_RED, 16'hFFE3);
    write_row(REG_UNUSED, 16'hFFFF);
    // countdown through -1 into yellow, then red; button ignored outside green
    tick_row(12'd2048, 1'b0);
    tick_row(12'd2048, 1'b0);
    tick_row(12'd2048, 1'b0);
    tick_row(12'd2048, 1'b0);
    tick_row(12'd2048, 1'b1);
    tick_row(12'd2048, 1'b1);
    // blink every tick, only 4095 counts as day
    write_row(REG_BLINK_TICKS, 16'd0);
    write_row(REG_THRESHOLD, 16'hF0FF & 16'h0FFF | 16'h0F00);
    tick_row(12'd4094, 1'b0);
    tick_row(12'd4094, 1'b1);
    tick_row(12'd4095, 1'b1);
    // pedestrian cut from 99 down to 0, countdown parked at the longest period
    write_row(REG_SHORT_GREEN, 16'hFF80);
    write_row(REG_GREEN, 16'h7FE3);
    write_row(REG_TICKS_SEC, 16'hFFFF);
    tick_row(12'd0, 1'b0);
    tick_row(12'd2048, 1'b1);
    tick_row(12'd2048, 1'b1);
    // threshold 0: night can never apply
    write_row(REG_THRESHOLD, 16'h0000);
    tick_row(12'd0, 1'b1);
    tick_row(12'd4095, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        sender_gap();
        offer_tick(plan[i].level, plan[i].button, plan[i].typed, plan[i].want);
      end
    end

    // ---- random part: eight setting phases of day/night runs ----
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 0)
        load_settings(0, 0, 0, 0, 0, 0, 0);
      else if (ph == 1)
        load_settings(99, 99, 99, 4095, 65535, 65535, 99);
      else
        load_settings($urandom_range(0, 7) == 0 ? 99 : $urandom_range(0, 9),
                      $urandom_range(0, 9), $urandom_range(0, 9),
                      $urandom_range(0, 4095),
                      $urandom_range(0, 7) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 4),
                      $urandom_range(0, 6), $urandom_range(0, 9));
      gap_pct = 15 * $urandom_range(0, 3);
      stall_pct = 15 * $urandom_range(0, 3);
      if (ph == 3) gap_pct = 0;   // keep offering while the receiver holds off
      thr = live_cfg.dark_level;
      run_left = 0;
      run_night = 1'b0;
      press_run = 1'b0;
      for (int k = 0; k < 100; k++) begin
        if (ph == 3 && k == 10) long_hold_req = 1'b1;
        // runs of one mode with random content, a few pure-noise samples
        if (run_left == 0) begin
          run_left = $urandom_range(1, 30);
          run_night = 1'($urandom_range(0, 1));
          press_run = $urandom_range(0, 2) == 0;
        end
        run_left--;
        case ($urandom_range(0, 9))
          0: lvl = 12'($urandom_range(0, 4095));
          1: lvl = (run_night && thr != 0) ? 12'(thr - 1) : 12'(thr);
          default:
            lvl = (run_night && thr != 0) ? 12'($urandom_range(0, thr - 1))
                                          : 12'($urandom_range(thr, 4095));
        endcase
        btn = press_run ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
        sender_gap();
        offer_tick(lvl, btn, 1'b0, none);
      end
    end

    // ---- final stretch, no idling: short periods so every event fires ----
    settle();
    idle_on = 1'b0;
    load_settings(5, 2, 5, 2048, 3, 2, 2);
    repeat (12) offer_tick(12'($urandom_range(0, 2047)), 1'($urandom), 1'b0, none);
    repeat (24) offer_tick(12'($urandom_range(2048, 4095)), 1'($urandom), 1'b0, none);
    repeat (3) offer_tick(12'($urandom_range(0, 2047)), 1'b0, 1'b0, none);
    repeat (3) offer_tick(12'($urandom_range(2048, 4095)), 1'b1, 1'b0, none);

    // drain, then a short tail to catch stray items
    settle();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (errors == 0)
      $display("tb_traffic_light_day_night_controller: clean");
    else
      $display("tb_traffic_light_day_night_controller: errors");
    $finish;
  end

endmodule
